[rtl/core/bcvs_pkg.sv]
// ----------------------------------------------------------------------------
// bcvs_pkg
// Shared types and constants for the breath cycle valve sequencer.
// ----------------------------------------------------------------------------
package bcvs_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CYCLES_PER_MINUTE = 2'd0,
    REG_PEEP_MINIMUM      = 2'd1,
    REG_PLATEAU_MAXIMUM   = 2'd2,
    REG_PEAK_MAXIMUM      = 2'd3
  } reg_index_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  // Serial divider sizing: 6000 ticks per minute over a rate of up to 35.
  localparam int DivDvdW = 13;
  localparam int DivDsrW = 6;

  typedef enum logic [1:0] {
    PH_PUSH     = 2'd0,
    PH_HOLD     = 2'd1,
    PH_EXP      = 2'd2,
    PH_HOLD_EXP = 2'd3
  } phase_t;

  typedef struct packed {
    logic sample_load;
    logic div_start;
    logic load_cycle;
    logic press_load;
    logic eval;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cycle_start;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

  localparam int InDataW  = 16;
  localparam int OutDataW = 64;

endpackage

[rtl/core/breath_cycle_valve_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// breath_cycle_valve_sequencer_unit
// Breath cycle sequencer: maps pressure samples to valve servo commands.
// ----------------------------------------------------------------------------
// Each transfer on the in_ channel is one 10 ms tick with a raw pressure
// sample; each produces exactly one transfer on the out_ channel with the
// phase, both servo angles, change flags, the pressure and the cycle's
// captures. out_tlast marks the last tick of a breath cycle.
// A tick's sample, then its pressure, then its result are registered; the
// next tick can be taken once that result is valid. On the first tick of
// each breath the cycle length is computed first by a serial divider that
// produces one quotient bit per clock; the inspiration length follows by a
// constant multiply. A new tick is taken only when the previous one is
// evaluated, but a result may still wait in the output register while the
// next tick is worked on; if the receiver stalls, evaluation of that next
// tick waits. The cfg_ port writes a setting at every clock with cfg_we high;
// the user must make writes only while the block is idle, which the block
// itself does not enforce. Rate, PEEP and plateau settings take effect at
// the next breath start, the peak limit at once. Synchronous reset restores
// the default settings and starts a new breath.
// ----------------------------------------------------------------------------
module breath_cycle_valve_sequencer_unit
  import bcvs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [9:0] adc_sample
  output logic                out_tvalid,
  input  logic                out_tready,
  // [1:0] phase, [9:2] blower_angle, [17:10] patient_angle, [18] blower_changed,
  // [19] patient_changed, [30:20] pressure, [41:31] peak_pressure,
  // [52:42] plateau_pressure, [63:53] peep_pressure
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast,  // cycle_end
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bcvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bcvs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample     (in_tdata[9:0]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/core/bcvs_divider.sv]
// ----------------------------------------------------------------------------
// bcvs_divider
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module bcvs_divider
  import bcvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DivDvdW-1:0] dividend,
  input  logic [DivDsrW-1:0] divisor,
  output logic [DivDvdW-1:0] quotient,
  output logic               done
);

  localparam int CntW = $clog2(DivDvdW);

  logic [DivDvdW-1:0] q_r, q_nxt;
  logic [DivDsrW-1:0] rem_r, rem_nxt;
  logic [DivDsrW-1:0] dsr_r;
  logic [CntW-1:0]    cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DivDsrW:0]   trial;
  logic               ge;

  // The dividend shifts out of the top of q_r while quotient bits enter below.
  assign trial = {rem_r, q_r[DivDvdW-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    q_nxt   = {q_r[DivDvdW-2:0], ge};
    rem_nxt = ge ? DivDsrW'(trial - {1'b0, dsr_r}) : trial[DivDsrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(DivDvdW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

[rtl/core/bcvs_datapath.sv]
// ----------------------------------------------------------------------------
// bcvs_datapath
// Settings, cycle timing, valve positions, captures and the result register.
// ----------------------------------------------------------------------------
module bcvs_datapath
  import bcvs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output ctrl_sts_t           sts,
  input  logic [9:0]          sample,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast
);

  localparam logic [7:0] AngleRest = 8'd90;
  localparam logic signed [10:0] CaptureNone = -11'sd1;
  localparam logic [DivDvdW-1:0] TicksPerMinute = DivDvdW'(6000);
  localparam int MagW = 15;
  // ceil(2^18/17) and ceil(2^11/3); both are exact over the operand ranges used.
  localparam logic [13:0] PressRecip = 14'd15421;
  localparam logic [9:0]  ThirdRecip = 10'd683;

  function automatic logic [7:0] clamp_angle(input logic signed [9:0] a);
    if (a < 10'sd0)        return 8'd0;
    else if (a > 10'sd180) return 8'd180;
    else                   return a[7:0];
  endfunction

  // Configuration registers.
  logic [5:0] rate_r;
  logic [4:0] peep_min_r;
  logic [5:0] plat_max_r;
  logic [6:0] peak_max_r;

  // Cycle state.
  logic [10:0]        tick_r;
  logic [10:0]        cyc_len_r;
  logic [9:0]         insp_len_r;
  logic [4:0]         peep_lat_r;
  logic [5:0]         plat_lat_r;
  logic [7:0]         blower_pos_r;
  logic [7:0]         patient_pos_r;
  logic signed [10:0] peak_cap_r;
  logic signed [10:0] plat_cap_r;
  logic signed [10:0] peep_cap_r;
  logic [9:0]         sample_r;
  logic signed [10:0] press_r;

  logic               out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= 6'd20;
      peep_min_r <= 5'd10;
      plat_max_r <= 6'd40;
      peak_max_r <= 7'd75;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_CYCLES_PER_MINUTE: rate_r     <= cfg_wdata[5:0];
        REG_PEEP_MINIMUM:      peep_min_r <= cfg_wdata[4:0];
        REG_PLATEAU_MAXIMUM:   plat_max_r <= cfg_wdata[5:0];
        REG_PEAK_MAXIMUM:      peak_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_load) sample_r <= sample;
  end

  // Pressure: trunc((raw-194)*600/51/10) equals sign * floor(|raw-194|*20/17).
  logic               neg;
  logic [9:0]         mag;
  logic [MagW-1:0]    mag20;
  logic [28:0]        press_prod;
  logic signed [10:0] p_mag;
  logic signed [10:0] press_val;
  logic [20:0]        third_prod;
  logic [5:0]         rate_sat;

  assign neg        = sample_r < 10'd194;
  assign mag        = neg ? 10'(10'd194 - sample_r) : 10'(sample_r - 10'd194);
  assign mag20      = {1'b0, mag, 4'b0} + {3'b0, mag, 2'b0};
  assign press_prod = 29'(mag20) * 29'(PressRecip);
  assign p_mag      = press_prod[28:18];
  assign press_val  = neg ? -p_mag : p_mag;
  assign rate_sat = (rate_r < 6'd5) ? 6'd5 : ((rate_r > 6'd35) ? 6'd35 : rate_r);

  always_ff @(posedge clk) begin
    if (cmd.press_load) press_r <= press_val;
  end

  logic [DivDvdW-1:0] div_q;
  logic               div_done;

  bcvs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (TicksPerMinute),
    .divisor  (rate_sat),
    .quotient (div_q),
    .done     (div_done)
  );

  // The inspiration length is a third of the freshly divided cycle length.
  assign third_prod = 21'(div_q[10:0]) * 21'(ThirdRecip);

  // Tick evaluation.
  logic signed [10:0] pressure;
  logic [10:0]        tick_nxt;
  phase_t             time_ph;
  phase_t             phase;
  logic signed [9:0]  blower_cmd;
  logic signed [9:0]  patient_cmd;
  logic [7:0]         blower_ang;
  logic [7:0]         patient_ang;
  logic               ending;

  assign pressure = press_r;
  assign tick_nxt = tick_r + 11'd1;

  always_comb begin
    if (tick_nxt <= {1'b0, insp_len_r}) begin
      time_ph = (tick_nxt <= {2'b0, insp_len_r[9:1]}) ? PH_PUSH : PH_HOLD;
    end else begin
      time_ph = PH_EXP;
    end
    phase = time_ph;
    unique case (time_ph)
      PH_PUSH: begin
        blower_cmd  = 10'sd75;
        patient_cmd = 10'sd70;
      end
      PH_HOLD: begin
        blower_cmd  = 10'sd70;
        patient_cmd = 10'sd70;
      end
      default: begin
        blower_cmd  = 10'sd40;
        patient_cmd = 10'sd30;
      end
    endcase
    if (pressure > $signed({4'b0, peak_max_r}))
      blower_cmd = $signed({2'b0, blower_pos_r}) - 10'sd2;
    if (time_ph == PH_HOLD && pressure > $signed({5'b0, plat_lat_r}))
      patient_cmd = $signed({2'b0, patient_pos_r}) + 10'sd1;
    if (pressure < $signed({6'b0, peep_lat_r})) begin
      patient_cmd = 10'sd90;
      phase       = PH_HOLD_EXP;
    end
    blower_ang  = clamp_angle(blower_cmd);
    patient_ang = clamp_angle(patient_cmd);
  end

  assign ending = tick_nxt >= cyc_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r        <= '0;
      cyc_len_r     <= 11'd300;
      insp_len_r    <= 10'd100;
      peep_lat_r    <= 5'd10;
      plat_lat_r    <= 6'd40;
      blower_pos_r  <= AngleRest;
      patient_pos_r <= AngleRest;
      peak_cap_r    <= CaptureNone;
      plat_cap_r    <= CaptureNone;
      peep_cap_r    <= CaptureNone;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_tready) out_valid_r <= 1'b0;
      if (cmd.load_cycle) begin
        cyc_len_r     <= div_q[10:0];
        insp_len_r    <= third_prod[20:11];
        peep_lat_r    <= peep_min_r;
        plat_lat_r    <= plat_max_r;
        blower_pos_r  <= AngleRest;
        patient_pos_r <= AngleRest;
        peak_cap_r    <= CaptureNone;
        plat_cap_r    <= CaptureNone;
        peep_cap_r    <= CaptureNone;
      end
      if (cmd.eval) begin
        tick_r        <= ending ? 11'd0 : tick_nxt;
        blower_pos_r  <= blower_ang;
        patient_pos_r <= patient_ang;
        out_valid_r   <= 1'b1;
        unique case (time_ph)
          PH_PUSH: peak_cap_r <= pressure;
          PH_HOLD: plat_cap_r <= pressure;
          default: peep_cap_r <= pressure;
        endcase
      end
    end
  end

  // Result payload; the captures already include this tick's pressure.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_data_r[1:0]   <= phase;
      out_data_r[9:2]   <= blower_ang;
      out_data_r[17:10] <= patient_ang;
      out_data_r[18]    <= blower_ang != blower_pos_r;
      out_data_r[19]    <= patient_ang != patient_pos_r;
      out_data_r[30:20] <= pressure;
      out_data_r[41:31] <= (time_ph == PH_PUSH) ? pressure : peak_cap_r;
      out_data_r[52:42] <= (time_ph == PH_HOLD) ? pressure : plat_cap_r;
      out_data_r[63:53] <= (time_ph == PH_EXP)  ? pressure : peep_cap_r;
      out_last_r        <= ending;
    end
  end

  assign sts.cycle_start = tick_r == 11'd0;
  assign sts.div_done    = div_done;
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A new result must never overwrite one that has not been transferred.
  a_eval_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r < cyc_len_r)
    else $error("tick count beyond cycle length");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    blower_pos_r <= 8'd180 && patient_pos_r <= 8'd180)
    else $error("valve position out of range");

  a_load_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_cycle |-> tick_r == 11'd0)
    else $error("cycle settings latched mid-cycle");

endmodule

[rtl/core/bcvs_ctrl.sv]
// ----------------------------------------------------------------------------
// bcvs_ctrl
// Sequencer: schedules the cycle division and the evaluation of one tick.
// ----------------------------------------------------------------------------
module bcvs_ctrl
  import bcvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RATE,
    S_PRESS,
    S_EVAL
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.sample_load = 1'b1;
          // The first tick of a cycle first works out the cycle timing.
          if (sts.cycle_start) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_RATE;
          end else begin
            state_nxt = S_PRESS;
          end
        end
      end
      S_RATE: begin
        if (sts.div_done) begin
          cmd.load_cycle = 1'b1;
          state_nxt      = S_PRESS;
        end
      end
      S_PRESS: begin
        cmd.press_load = 1'b1;
        state_nxt      = S_EVAL;
      end
      S_EVAL: begin
        if (sts.out_free) begin
          cmd.eval  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
